// ===== sv/dbeq_pkg.sv =====
`default_nettype none

package dbeq_pkg;

    localparam int DEPTH_DEF       = 16;
    localparam int TAG_BITS_DEF    = 16;
    localparam int HANDLE_BITS_DEF = 32;

    localparam int FUNC_W     = 2;
    localparam int STATUS_W   = 3;
    localparam int CAP_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_NONE_TAG = CFG_IDX_W'(1);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_POST  = 2'd0,
        FUNC_POP   = 2'd1,
        FUNC_CLOSE = 2'd2
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_POSTED  = 3'd0,
        ST_CLOSED  = 3'd1,
        ST_FULL    = 3'd2,
        ST_DUP     = 3'd3,
        ST_POPPED  = 3'd4,
        ST_EMPTY   = 3'd5,
        ST_FLUSHED = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_POP,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

// ===== sv/dbeq_ifs.sv =====
`default_nettype none

interface dbeq_req_if #(
    parameter int TAG_BITS    = dbeq_pkg::TAG_BITS_DEF,
    parameter int HANDLE_BITS = dbeq_pkg::HANDLE_BITS_DEF
);
    import dbeq_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [FUNC_W-1:0]      func;
    logic [TAG_BITS-1:0]    tag;
    logic [HANDLE_BITS-1:0] handle;

    modport source (output valid, func, tag, handle, input ready);
    modport sink   (input valid, func, tag, handle, output ready);
endinterface

interface dbeq_rsp_if #(
    parameter int DEPTH       = dbeq_pkg::DEPTH_DEF,
    parameter int TAG_BITS    = dbeq_pkg::TAG_BITS_DEF,
    parameter int HANDLE_BITS = dbeq_pkg::HANDLE_BITS_DEF
);
    import dbeq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                   valid;
    logic                   ready;
    status_t                status;
    logic [TAG_BITS-1:0]    out_tag;
    logic [HANDLE_BITS-1:0] out_handle;
    logic [CNT_W-1:0]       fill;

    modport source (output valid, status, out_tag, out_handle, fill, input ready);
    modport sink   (input valid, status, out_tag, out_handle, fill, output ready);
endinterface

interface dbeq_cfg_if;
    import dbeq_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/dbeq_ram.sv =====
`default_nettype none

module dbeq_ram #(
    parameter int WIDTH = dbeq_pkg::TAG_BITS_DEF + dbeq_pkg::HANDLE_BITS_DEF,
    parameter int DEPTH = dbeq_pkg::DEPTH_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== sv/dbeq_ctrl.sv =====
`default_nettype none

module dbeq_ctrl #(
    parameter int DEPTH       = dbeq_pkg::DEPTH_DEF,
    parameter int TAG_BITS    = dbeq_pkg::TAG_BITS_DEF,
    parameter int HANDLE_BITS = dbeq_pkg::HANDLE_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    dbeq_req_if.sink                                 req,
    dbeq_rsp_if.source                               rsp,
    input  wire logic [dbeq_pkg::CAP_W-1:0]          cap,
    input  wire logic [TAG_BITS-1:0]                 none_tag,
    output      logic                                ram_we,
    output      logic [$clog2(DEPTH)-1:0]            ram_waddr,
    output      logic [TAG_BITS+HANDLE_BITS-1:0]     ram_wdata,
    output      logic                                ram_re,
    output      logic [$clog2(DEPTH)-1:0]            ram_raddr,
    input  wire logic [TAG_BITS+HANDLE_BITS-1:0]     ram_rdata
);
    import dbeq_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] n;
        n = p + PTR_W'(1);
        if (p == PTR_W'(DEPTH - 1))
        begin
            n = '0;
        end
        return n;
    endfunction

    state_t                 state_reg, state_next;
    logic [PTR_W-1:0]       head_reg, head_next;
    logic [PTR_W-1:0]       tail_reg, tail_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   closed_reg, closed_next;
    logic [PTR_W-1:0]       scan_ptr_reg, scan_ptr_next;
    logic [CNT_W-1:0]       iss_cnt_reg, iss_cnt_next;
    logic [CNT_W-1:0]       cmp_cnt_reg, cmp_cnt_next;
    logic                   cmp_vld_reg, cmp_vld_next;
    logic [TAG_BITS-1:0]    tag_reg, tag_next;
    logic [HANDLE_BITS-1:0] handle_reg, handle_next;
    status_t                res_status_reg, res_status_next;
    logic [TAG_BITS-1:0]    res_tag_reg, res_tag_next;
    logic [HANDLE_BITS-1:0] res_handle_reg, res_handle_next;
    logic                   rsp_vld_reg, rsp_vld_next;
    status_t                out_status_reg, out_status_next;
    logic [TAG_BITS-1:0]    out_tag_reg, out_tag_next;
    logic [HANDLE_BITS-1:0] out_handle_reg, out_handle_next;
    logic [CNT_W-1:0]       out_fill_reg, out_fill_next;

    logic [CMP_W-1:0]       cap_ext;
    logic [CMP_W-1:0]       limit;
    logic                   full;
    logic                   accept;
    logic [TAG_BITS-1:0]    rd_tag;
    logic [HANDLE_BITS-1:0] rd_handle;
    logic                   hit;
    logic                   last_cmp;

    // Capacity above the queue depth saturates at the depth.
    assign cap_ext   = CMP_W'(cap);
    assign limit     = (cap_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_ext;
    assign full      = CMP_W'(count_reg) >= limit;
    assign accept    = req.valid && req.ready;
    assign rd_tag    = ram_rdata[HANDLE_BITS +: TAG_BITS];
    assign rd_handle = ram_rdata[HANDLE_BITS-1:0];
    assign hit       = cmp_vld_reg && (rd_tag == tag_reg);
    assign last_cmp  = cmp_vld_reg && ((cmp_cnt_reg + CNT_W'(1)) == count_reg);

    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = rsp_vld_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.out_tag    = out_tag_reg;
    assign rsp.out_handle = out_handle_reg;
    assign rsp.fill       = out_fill_reg;

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        closed_next     = closed_reg;
        scan_ptr_next   = scan_ptr_reg;
        iss_cnt_next    = iss_cnt_reg;
        cmp_cnt_next    = cmp_cnt_reg;
        cmp_vld_next    = 1'b0;
        tag_next        = tag_reg;
        handle_next     = handle_reg;
        res_status_next = res_status_reg;
        res_tag_next    = res_tag_reg;
        res_handle_next = res_handle_reg;
        rsp_vld_next    = rsp_vld_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_tag_next    = out_tag_reg;
        out_handle_next = out_handle_reg;
        out_fill_next   = out_fill_reg;
        ram_we          = 1'b0;
        ram_waddr       = tail_reg;
        ram_wdata       = {tag_reg, handle_reg};
        ram_re          = 1'b0;
        ram_raddr       = head_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    tag_next        = req.tag;
                    handle_next     = req.handle;
                    res_tag_next    = '0;
                    res_handle_next = '0;
                    case (func_t'(req.func))
                        FUNC_POST:
                        begin
                            state_next = S_DONE;
                            if (closed_reg)
                            begin
                                res_status_next = ST_CLOSED;
                            end
                            else if (full)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else if (req.tag == none_tag || count_reg == '0)
                            begin
                                ram_we          = 1'b1;
                                ram_wdata       = {req.tag, req.handle};
                                tail_next       = next_slot(tail_reg);
                                count_next      = count_reg + CNT_W'(1);
                                res_status_next = ST_POSTED;
                            end
                            else
                            begin
                                // The first tag read goes out now, at the head.
                                ram_re        = 1'b1;
                                scan_ptr_next = next_slot(head_reg);
                                iss_cnt_next  = CNT_W'(1);
                                cmp_cnt_next  = '0;
                                cmp_vld_next  = 1'b1;
                                state_next    = S_SCAN;
                            end
                        end
                        FUNC_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = ST_EMPTY;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                state_next = S_POP;
                            end
                        end
                        FUNC_CLOSE:
                        begin
                            closed_next     = 1'b1;
                            head_next       = '0;
                            tail_next       = '0;
                            count_next      = '0;
                            res_status_next = ST_FLUSHED;
                            state_next      = S_DONE;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // Each read is issued in the cycle before its tag compare.
                if (cmp_vld_reg)
                begin
                    cmp_cnt_next = cmp_cnt_reg + CNT_W'(1);
                end
                if (hit)
                begin
                    res_status_next = ST_DUP;
                    state_next      = S_DONE;
                end
                else if (last_cmp)
                begin
                    ram_we          = 1'b1;
                    tail_next       = next_slot(tail_reg);
                    count_next      = count_reg + CNT_W'(1);
                    res_status_next = ST_POSTED;
                    state_next      = S_DONE;
                end
                else if (iss_cnt_reg < count_reg)
                begin
                    ram_re        = 1'b1;
                    ram_raddr     = scan_ptr_reg;
                    scan_ptr_next = next_slot(scan_ptr_reg);
                    iss_cnt_next  = iss_cnt_reg + CNT_W'(1);
                    cmp_vld_next  = 1'b1;
                end
            end
            S_POP:
            begin
                res_tag_next    = rd_tag;
                res_handle_next = rd_handle;
                res_status_next = ST_POPPED;
                head_next       = next_slot(head_reg);
                count_next      = count_reg - CNT_W'(1);
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (!rsp_vld_reg || rsp.ready)
                begin
                    rsp_vld_next    = 1'b1;
                    out_status_next = res_status_reg;
                    out_tag_next    = res_tag_reg;
                    out_handle_next = res_handle_reg;
                    out_fill_next   = count_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            closed_reg   <= 1'b0;
            scan_ptr_reg <= '0;
            iss_cnt_reg  <= '0;
            cmp_cnt_reg  <= '0;
            cmp_vld_reg  <= 1'b0;
            rsp_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            closed_reg   <= closed_next;
            scan_ptr_reg <= scan_ptr_next;
            iss_cnt_reg  <= iss_cnt_next;
            cmp_cnt_reg  <= cmp_cnt_next;
            cmp_vld_reg  <= cmp_vld_next;
            rsp_vld_reg  <= rsp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg        <= tag_next;
        handle_reg     <= handle_next;
        res_status_reg <= res_status_next;
        res_tag_reg    <= res_tag_next;
        res_handle_reg <= res_handle_next;
        out_status_reg <= out_status_next;
        out_tag_reg    <= out_tag_next;
        out_handle_reg <= out_handle_next;
        out_fill_reg   <= out_fill_next;
    end

`ifndef ASSERT_OFF
    a_closed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        closed_reg |=> closed_reg)
        else $error("closed flag dropped without reset");

    a_closed_empty: assert property (@(posedge clk) disable iff (!rst_n)
        closed_reg |-> (count_reg == '0))
        else $error("closed queue holds entries");

    a_scan_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (!closed_reg && count_reg != '0))
        else $error("tag scan on a closed or empty queue");

    a_scan_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (cmp_cnt_reg <= iss_cnt_reg && iss_cnt_reg <= count_reg))
        else $error("tag scan counters out of order");

    a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && (!rsp_vld_reg || rsp.ready)) |=> rsp_vld_reg)
        else $error("finished result not presented");
`endif

endmodule

`default_nettype wire

// ===== sv/dedup_bounded_event_queue_unit.sv =====
// Deduplicating bounded event queue.
// The req channel carries one operation per beat: post (tag, handle), pop
// the oldest entry, or close and flush. Code three is dropped without a
// result. Every other beat yields exactly one beat on the rsp channel with
// a status, the popped tag and handle (zero unless popped), and the fill.
// The cfg channel writes capacity (index 0) and the untagged value
// (index 1); it is always ready and is meant to be used while idle.
// Close, refused posts and posts that need no tag check (empty queue or the
// untagged value) go straight to the result stage; a pop first reads the
// head entry from the RAM, and a checked post walks the stored tags with
// one shared compare, one RAM read per cycle, until a match or the last
// entry. The block takes one operation at a time; req is ready again once
// the result sits in the output register, so the next beat can be taken
// while the result is offered. A stalled receiver holds the result in that
// register; a following operation is taken and worked, then waits for the
// register to free. Reset empties the queue, opens it and restores
// capacity 16 and tag 0. The entry RAM is not cleared; only written slots
// are ever read.
`default_nettype none

module dedup_bounded_event_queue_unit #(
    parameter int DEPTH       = dbeq_pkg::DEPTH_DEF,
    parameter int TAG_BITS    = dbeq_pkg::TAG_BITS_DEF,
    parameter int HANDLE_BITS = dbeq_pkg::HANDLE_BITS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    dbeq_req_if.sink   req,
    dbeq_rsp_if.source rsp,
    dbeq_cfg_if.sink   cfg
);
    import dbeq_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int ENT_W = TAG_BITS + HANDLE_BITS;

    logic [CAP_W-1:0]    cap_reg, cap_next;
    logic [TAG_BITS-1:0] none_tag_reg, none_tag_next;

    logic             ram_we;
    logic [PTR_W-1:0] ram_waddr;
    logic [ENT_W-1:0] ram_wdata;
    logic             ram_re;
    logic [PTR_W-1:0] ram_raddr;
    logic [ENT_W-1:0] ram_rdata;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        cap_next      = cap_reg;
        none_tag_next = none_tag_reg;
        if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_CAPACITY: cap_next      = cfg.data[CAP_W-1:0];
                CFG_NONE_TAG: none_tag_next = TAG_BITS'(cfg.data);
                default:      cap_next      = cap_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg      <= CAP_RESET;
            none_tag_reg <= '0;
        end
        else
        begin
            cap_reg      <= cap_next;
            none_tag_reg <= none_tag_next;
        end
    end

    dbeq_ctrl #(
        .DEPTH       (DEPTH),
        .TAG_BITS    (TAG_BITS),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cap       (cap_reg),
        .none_tag  (none_tag_reg),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    dbeq_ram #(
        .WIDTH (ENT_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`default_nettype none

module tb;
    import dbeq_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int unsigned RUN_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 32;
    localparam int HOLD_CYCLES = 300;
    localparam int PRINT_LIMIT = 50;

    typedef struct {
        logic [TAG_BITS_DEF-1:0]    tag;
        logic [HANDLE_BITS_DEF-1:0] handle;
    } entry_t;

    typedef struct {
        status_t                    status;
        logic [TAG_BITS_DEF-1:0]    tag;
        logic [HANDLE_BITS_DEF-1:0] handle;
        logic [CAP_W-1:0]           fill;
    } outcome_t;

    class queue_scoreboard;
        entry_t            held[$];
        outcome_t          expected[$];
        bit                is_closed;
        logic [CAP_W-1:0]  cap_reg;
        logic [15:0]       none_reg;
        int unsigned       err_count;
        int unsigned       ops_noted;
        int unsigned       results_seen;
        int unsigned       status_hits[8];

        function new();
            is_closed = 1'b0;
            cap_reg = CAP_RESET;
            none_reg = '0;
            err_count = 0;
            ops_noted = 0;
            results_seen = 0;
            foreach (status_hits[i]) status_hits[i] = 0;
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
            if (idx == CFG_CAPACITY)
                cap_reg = value[CAP_W-1:0];
            else if (idx == CFG_NONE_TAG)
                none_reg = value;
        endfunction

        function int pending();
            return expected.size();
        endfunction

        // Works out what one accepted request beat must produce.
        function void note_op(input logic [FUNC_W-1:0] f,
                              input logic [TAG_BITS_DEF-1:0] t,
                              input logic [HANDLE_BITS_DEF-1:0] h);
            outcome_t o;
            entry_t   e;
            int       limit;
            bit       seen;
            o.tag = '0;
            o.handle = '0;
            case (f)
                FUNC_POST:
                begin
                    limit = (cap_reg > DEPTH_DEF) ? DEPTH_DEF : int'(cap_reg);
                    seen = 1'b0;
                    foreach (held[i])
                        if (held[i].tag == t)
                            seen = 1'b1;
                    if (is_closed)
                        o.status = ST_CLOSED;
                    else if (held.size() >= limit)
                        o.status = ST_FULL;
                    else if (t != none_reg && seen)
                        o.status = ST_DUP;
                    else
                    begin
                        e.tag = t;
                        e.handle = h;
                        held.push_back(e);
                        o.status = ST_POSTED;
                    end
                end
                FUNC_POP:
                begin
                    if (held.size() == 0)
                        o.status = ST_EMPTY;
                    else
                    begin
                        e = held[0];
                        held.delete(0);
                        o.tag = e.tag;
                        o.handle = e.handle;
                        o.status = ST_POPPED;
                    end
                end
                FUNC_CLOSE:
                begin
                    is_closed = 1'b1;
                    held.delete();
                    o.status = ST_FLUSHED;
                end
                default:
                    return;
            endcase
            o.fill = CAP_W'(held.size());
            expected.push_back(o);
            ops_noted++;
        endfunction

        task log_mismatch(input string what);
            // Keep the log short if the block is badly broken; all are counted.
            if (err_count < PRINT_LIMIT)
                $display("mismatch at %0t: %s", $realtime, what);
            err_count++;
        endtask

        task check_result(input status_t s, input logic [TAG_BITS_DEF-1:0] t,
                          input logic [HANDLE_BITS_DEF-1:0] h,
                          input logic [CAP_W-1:0] fill);
            outcome_t o;
            if (expected.size() == 0)
            begin
                log_mismatch($sformatf("unexpected result beat, status %0d", s));
                return;
            end
            o = expected[0];
            expected.delete(0);
            results_seen++;
            status_hits[int'(o.status)]++;
            if (s !== o.status)
                log_mismatch($sformatf("status %0d, want %0d", s, o.status));
            if (t !== o.tag)
                log_mismatch($sformatf("out_tag %h, want %h", t, o.tag));
            if (h !== o.handle)
                log_mismatch($sformatf("out_handle %h, want %h", h, o.handle));
            if (fill !== o.fill)
                log_mismatch($sformatf("fill %0d, want %0d", fill, o.fill));
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic hold_on;
    event hold_go;
    int   send_idle_pct;
    int   rsp_stall_pct;
    int unsigned cycle_count = 0;
    queue_scoreboard sb;

    logic [15:0] tag_pool [8] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000,
                                  16'h5555, 16'hAAAA, 16'h1234, 16'hFEDC};

    dbeq_req_if req_ch ();
    dbeq_rsp_if rsp_ch ();
    dbeq_cfg_if cfg_ch ();

    dedup_bounded_event_queue_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin : watchdog
        while (cycle_count < RUN_LIMIT)
            @(posedge clk);
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, sb.pending());
        $display("FAIL");
        $finish;
    end

    // Long receiver hold-off, timed in its own process on the falling edge.
    initial
    begin : rsp_hold
        hold_on = 1'b0;
        @(hold_go);
        @(negedge clk);
        hold_on = 1'b1;
        for (int n = 0; n < HOLD_CYCLES; n++)
            @(negedge clk);
        hold_on = 1'b0;
    end

    initial
    begin : rsp_drain
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
                sb.check_result(rsp_ch.status, rsp_ch.out_tag, rsp_ch.out_handle,
                                rsp_ch.fill);
            rsp_ch.ready <= !hold_on && ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    function automatic logic [15:0] pick_tag();
        int r;
        r = $urandom_range(99);
        if (r < 40)
            return tag_pool[$urandom_range(7)];
        if (r < 50)
            return sb.none_reg;
        return 16'($urandom);
    endfunction

    // Offers one request beat. Valid stays high after acceptance so that a
    // back-to-back beat never lowers and raises it within one step.
    task automatic send_op(input logic [FUNC_W-1:0] f, input logic [15:0] t,
                           input logic [31:0] h);
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.func <= f;
        req_ch.tag <= t;
        req_ch.handle <= h;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        sb.note_op(f, t, h);
    endtask

    task automatic quiesce();
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        // An ignored beat leaves no result behind, so give the block time.
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [CAP_W-1:0] cap, input logic [15:0] untagged);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_CAPACITY;
        cfg_ch.data <= CFG_DATA_W'(cap);
        @(posedge clk);
        while (cfg_ch.ready !== 1'b1)
            @(posedge clk);
        sb.write_reg(CFG_CAPACITY, CFG_DATA_W'(cap));
        cfg_ch.index <= CFG_NONE_TAG;
        cfg_ch.data <= untagged;
        @(posedge clk);
        while (cfg_ch.ready !== 1'b1)
            @(posedge clk);
        sb.write_reg(CFG_NONE_TAG, untagged);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_random(input int count, input int post_pct);
        int done;
        int r;
        done = 0;
        while (done < count)
        begin
            r = $urandom_range(99);
            if (r < post_pct)
                send_op(FUNC_POST, pick_tag(), $urandom);
            else if (r < 96)
                send_op(FUNC_POP, 16'($urandom), $urandom);
            else
                send_op(FUNC_UNUSED, 16'($urandom), $urandom);
            if (r < 96)
                done++;
        end
    endtask

    initial
    begin : stimulus
        req_ch.valid = 1'b0;
        req_ch.func = FUNC_POST;
        req_ch.tag = '0;
        req_ch.handle = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_CAPACITY;
        cfg_ch.data = '0;
        rsp_ch.ready = 1'b0;
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        sb = new();
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: capacity 16, untagged value zero.
        send_op(FUNC_POP, 16'hFFFF, 32'hFFFF_FFFF);
        send_op(FUNC_POST, 16'h0000, 32'h0000_0000);
        send_op(FUNC_POST, 16'h0000, 32'hFFFF_FFFF);
        send_op(FUNC_POST, 16'hFFFF, 32'hA5A5_A5A5);
        send_op(FUNC_POST, 16'hFFFF, 32'h5A5A_5A5A);
        send_op(FUNC_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
        send_op(FUNC_POST, 16'h8001, 32'h1234_5678);
        repeat (5) send_op(FUNC_POP, 16'h0000, 32'h0000_0000);
        quiesce();

        // Full is tested before a duplicate; the untagged value is exempt.
        set_config(5'd2, 16'hFFFF);
        send_op(FUNC_POST, 16'hFFFF, 32'h0000_0000);
        send_op(FUNC_POST, 16'hFFFF, 32'hFFFF_FFFF);
        send_op(FUNC_POST, 16'hFFFF, 32'h0F0F_0F0F);
        send_op(FUNC_POP, 16'h0000, 32'h0000_0000);
        send_op(FUNC_POST, 16'h0000, 32'h8000_0001);
        send_op(FUNC_POP, 16'h0000, 32'h0000_0000);
        send_op(FUNC_POST, 16'h0000, 32'h7FFF_FFFE);
        repeat (3) send_op(FUNC_POP, 16'h0000, 32'h0000_0000);
        quiesce();

        set_config(5'd0, 16'h0000);
        send_op(FUNC_POST, 16'h4321, 32'hDEAD_BEEF);
        send_op(FUNC_POP, 16'h0000, 32'h0000_0000);
        quiesce();

        // Capacity above the depth saturates at the depth.
        set_config(5'd31, 16'h5555);
        run_random(90, 65);
        quiesce();

        send_idle_pct = 78;
        set_config(5'd17, 16'($urandom));
        run_random(85, 55);
        quiesce();

        send_idle_pct = 0;
        rsp_stall_pct = 78;
        set_config(5'd1, 16'hAAAA);
        run_random(80, 50);
        quiesce();

        send_idle_pct = 12;
        rsp_stall_pct = 12;
        set_config(5'd16, 16'hFFFF);
        run_random(85, 60);
        quiesce();

        // Receiver holds off while the sender keeps offering beats.
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        set_config(CAP_W'($urandom_range(4, 16)), 16'($urandom));
        -> hold_go;
        run_random(40, 75);
        quiesce();

        send_idle_pct = 12;
        rsp_stall_pct = 12;
        set_config(CAP_W'($urandom_range(0, 31)), 16'($urandom));
        run_random(60, 50);
        quiesce();

        // Close latches until reset, so it comes last.
        set_config(5'd3, 16'h0000);
        repeat (4) send_op(FUNC_POST, 16'($urandom), $urandom);
        send_op(FUNC_CLOSE, 16'($urandom), $urandom);
        quiesce();
        set_config(5'd0, 16'h1234);
        send_op(FUNC_POST, 16'h1234, $urandom);
        send_op(FUNC_POP, 16'($urandom), $urandom);
        send_op(FUNC_CLOSE, 16'($urandom), $urandom);
        send_op(FUNC_UNUSED, 16'($urandom), $urandom);
        send_op(FUNC_POST, 16'($urandom), $urandom);
        quiesce();

        $display("Run covered %0d operations and %0d checked results under free flow,",
                 sb.ops_noted, sb.results_seen);
        $display("idle, stall and hold-off; posted %0d full %0d dup %0d popped %0d empty %0d",
                 sb.status_hits[ST_POSTED], sb.status_hits[ST_FULL],
                 sb.status_hits[ST_DUP], sb.status_hits[ST_POPPED],
                 sb.status_hits[ST_EMPTY]);
        if (sb.err_count == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
